/* rtl/mics_pkg.sv */
// Package for the MIPS I integer core step block: opcodes, function codes,
// load kinds, sequencer states and the multiply/divide command type.
// No dependencies.
package mics_pkg;

    localparam int unsigned XLEN = 32;

    // primary opcodes
    localparam logic [5:0] OP_SPECIAL = 6'd0;
    localparam logic [5:0] OP_REGIMM  = 6'd1;
    localparam logic [5:0] OP_J       = 6'd2;
    localparam logic [5:0] OP_JAL     = 6'd3;
    localparam logic [5:0] OP_BEQ     = 6'd4;
    localparam logic [5:0] OP_BNE     = 6'd5;
    localparam logic [5:0] OP_BLEZ    = 6'd6;
    localparam logic [5:0] OP_BGTZ    = 6'd7;
    localparam logic [5:0] OP_ADDI    = 6'd8;
    localparam logic [5:0] OP_ADDIU   = 6'd9;
    localparam logic [5:0] OP_SLTI    = 6'd10;
    localparam logic [5:0] OP_SLTIU   = 6'd11;
    localparam logic [5:0] OP_ANDI    = 6'd12;
    localparam logic [5:0] OP_ORI     = 6'd13;
    localparam logic [5:0] OP_XORI    = 6'd14;
    localparam logic [5:0] OP_LUI     = 6'd15;
    localparam logic [5:0] OP_LB      = 6'd32;
    localparam logic [5:0] OP_LH      = 6'd33;
    localparam logic [5:0] OP_LW      = 6'd35;
    localparam logic [5:0] OP_LBU     = 6'd36;
    localparam logic [5:0] OP_LHU     = 6'd37;
    localparam logic [5:0] OP_SB      = 6'd40;
    localparam logic [5:0] OP_SH      = 6'd41;
    localparam logic [5:0] OP_SW      = 6'd43;

    // special function codes
    localparam logic [5:0] FN_SLL     = 6'd0;
    localparam logic [5:0] FN_SRL     = 6'd2;
    localparam logic [5:0] FN_SRA     = 6'd3;
    localparam logic [5:0] FN_SLLV    = 6'd4;
    localparam logic [5:0] FN_SRLV    = 6'd6;
    localparam logic [5:0] FN_SRAV    = 6'd7;
    localparam logic [5:0] FN_JR      = 6'd8;
    localparam logic [5:0] FN_JALR    = 6'd9;
    localparam logic [5:0] FN_SYSCALL = 6'd12;
    localparam logic [5:0] FN_MFHI    = 6'd16;
    localparam logic [5:0] FN_MTHI    = 6'd17;
    localparam logic [5:0] FN_MFLO    = 6'd18;
    localparam logic [5:0] FN_MTLO    = 6'd19;
    localparam logic [5:0] FN_MULT    = 6'd24;
    localparam logic [5:0] FN_MULTU   = 6'd25;
    localparam logic [5:0] FN_DIV     = 6'd26;
    localparam logic [5:0] FN_DIVU    = 6'd27;
    localparam logic [5:0] FN_ADD     = 6'd32;
    localparam logic [5:0] FN_ADDU    = 6'd33;
    localparam logic [5:0] FN_SUB     = 6'd34;
    localparam logic [5:0] FN_SUBU    = 6'd35;
    localparam logic [5:0] FN_AND     = 6'd36;
    localparam logic [5:0] FN_OR      = 6'd37;
    localparam logic [5:0] FN_XOR     = 6'd38;
    localparam logic [5:0] FN_NOR     = 6'd39;
    localparam logic [5:0] FN_SLT     = 6'd42;
    localparam logic [5:0] FN_SLTU    = 6'd43;

    localparam logic [4:0] RT_BLTZAL  = 5'h10;
    localparam logic [4:0] REG_RA     = 5'd31;

    // memory request and width codes
    localparam logic [1:0] MREQ_NONE  = 2'd0;
    localparam logic [1:0] MREQ_LOAD  = 2'd1;
    localparam logic [1:0] MREQ_STORE = 2'd2;
    localparam logic [1:0] MW_BYTE    = 2'd0;
    localparam logic [1:0] MW_HALF    = 2'd1;
    localparam logic [1:0] MW_WORD    = 2'd2;

    typedef enum logic [2:0] {
        LK_NONE = 3'd0,
        LK_LB   = 3'd1,
        LK_LH   = 3'd2,
        LK_LW   = 3'd3,
        LK_LBU  = 3'd4,
        LK_LHU  = 3'd5
    } load_kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_READ,
        ST_EXEC,
        ST_MDU,
        ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        MD_MULT,
        MD_MULTU,
        MD_DIV,
        MD_DIVU
    } md_op_t;

    typedef struct packed {
        logic   start;
        md_op_t op;
    } md_cmd_t;

    typedef struct packed {
        logic        busy;
        logic        done;
        logic        write;
        logic [31:0] hi;
        logic [31:0] lo;
    } md_stat_t;

endpackage

/* rtl/mics_ram.sv */
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module mics_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 32
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem_reg [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        rdata <= mem_reg[raddr];
    end
endmodule

/* rtl/mics_regfile.sv */
// Register file: two RAM banks for two read ports, valid bits give zero reset.
// Depends on mics_ram.
module mics_regfile (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        we,
    input  logic [4:0]  waddr,
    input  logic [31:0] wdata,
    input  logic [4:0]  raddr_a,
    input  logic [4:0]  raddr_b,
    output logic [31:0] rdata_a,
    output logic [31:0] rdata_b
);
    logic [31:0] valid_reg;
    logic [31:0] ram_a;
    logic [31:0] ram_b;
    logic        va_reg;
    logic        vb_reg;
    logic        wr;

    assign wr = we && (waddr != 5'd0);

    mics_ram #(.WIDTH(32), .DEPTH(32)) u_bank_a (
        .aclk(aclk), .we(wr), .waddr(waddr), .wdata(wdata),
        .raddr(raddr_a), .rdata(ram_a)
    );
    mics_ram #(.WIDTH(32), .DEPTH(32)) u_bank_b (
        .aclk(aclk), .we(wr), .waddr(waddr), .wdata(wdata),
        .raddr(raddr_b), .rdata(ram_b)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
            va_reg    <= 1'b0;
            vb_reg    <= 1'b0;
        end else begin
            if (wr) begin
                valid_reg[waddr] <= 1'b1;
            end
            va_reg <= valid_reg[raddr_a];
            vb_reg <= valid_reg[raddr_b];
        end
    end

    assign rdata_a = va_reg ? ram_a : '0;
    assign rdata_b = vb_reg ? ram_b : '0;
endmodule

/* rtl/mics_muldiv.sv */
// Bit-serial multiply/divide unit: one bit per cycle, 32 steps plus sign fix.
// Depends on mics_pkg.
module mics_muldiv (
    input  logic              aclk,
    input  logic              aresetn,
    input  mics_pkg::md_cmd_t cmd,
    input  logic [31:0]       op_a,
    input  logic [31:0]       op_b,
    output mics_pkg::md_stat_t stat
);
    logic               busy_reg, busy_next;
    logic               fix_reg, fix_next;
    logic [5:0]         cnt_reg, cnt_next;
    mics_pkg::md_op_t   op_reg, op_next;
    logic [31:0]        acc_reg, acc_next;   // product high / remainder
    logic [31:0]        q_reg, q_next;       // multiplier / quotient
    logic [31:0]        m_reg, m_next;       // multiplicand / divisor
    logic               nq_reg, nq_next;
    logic               nr_reg, nr_next;
    logic               done_reg, done_next;
    logic               wr_reg, wr_next;
    logic [32:0]        sum;
    logic [32:0]        diff;
    logic [31:0]        abs_a, abs_b;
    logic               is_signed_div;
    logic [63:0]        neg_prod;

    assign abs_a = op_a[31] ? (32'd0 - op_a) : op_a;
    assign abs_b = op_b[31] ? (32'd0 - op_b) : op_b;
    assign is_signed_div = (cmd.op == mics_pkg::MD_DIV);
    assign sum  = {1'b0, acc_reg} + {1'b0, (q_reg[0] ? m_reg : 32'd0)};
    assign diff = {acc_reg, q_reg[31]} - {1'b0, m_reg};
    assign neg_prod = 64'd0 - {acc_reg, q_reg};

    always_comb begin
        busy_next = busy_reg;
        fix_next  = 1'b0;
        cnt_next  = cnt_reg;
        op_next   = op_reg;
        acc_next  = acc_reg;
        q_next    = q_reg;
        m_next    = m_reg;
        nq_next   = nq_reg;
        nr_next   = nr_reg;
        done_next = 1'b0;
        wr_next   = 1'b0;
        if (cmd.start) begin
            op_next  = cmd.op;
            cnt_next = 6'd0;
            acc_next = '0;
            if (cmd.op == mics_pkg::MD_MULTU || cmd.op == mics_pkg::MD_DIVU) begin
                q_next  = op_a;
                m_next  = op_b;
                nq_next = 1'b0;
                nr_next = 1'b0;
            end else begin
                q_next  = abs_a;
                m_next  = abs_b;
                nq_next = op_a[31] ^ op_b[31];
                nr_next = is_signed_div ? op_a[31] : 1'b0;
            end
            if ((cmd.op == mics_pkg::MD_DIV || cmd.op == mics_pkg::MD_DIVU)
                && op_b == 32'd0) begin
                done_next = 1'b1;   // divide by zero: leave hi/lo alone
            end else begin
                busy_next = 1'b1;
            end
        end else if (busy_reg && !fix_reg) begin
            if (op_reg == mics_pkg::MD_MULT || op_reg == mics_pkg::MD_MULTU) begin
                acc_next = sum[32:1];
                q_next   = {sum[0], q_reg[31:1]};
            end else if (!diff[32]) begin
                acc_next = diff[31:0];
                q_next   = {q_reg[30:0], 1'b1};
            end else begin
                acc_next = {acc_reg[30:0], q_reg[31]};
                q_next   = {q_reg[30:0], 1'b0};
            end
            cnt_next = cnt_reg + 6'd1;
            if (cnt_reg == 6'd31) begin
                fix_next = 1'b1;
            end
        end else if (busy_reg) begin
            if (op_reg == mics_pkg::MD_MULT) begin
                if (nq_reg) begin
                    acc_next = neg_prod[63:32];
                    q_next   = neg_prod[31:0];
                end
            end else if (op_reg == mics_pkg::MD_DIV) begin
                if (nq_reg) q_next = 32'd0 - q_reg;
                if (nr_reg) acc_next = 32'd0 - acc_reg;
            end
            busy_next = 1'b0;
            done_next = 1'b1;
            wr_next   = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            fix_reg  <= 1'b0;
            done_reg <= 1'b0;
            wr_reg   <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            fix_reg  <= fix_next;
            done_reg <= done_next;
            wr_reg   <= wr_next;
        end
    end

    always_ff @(posedge aclk) begin
        cnt_reg <= cnt_next;
        op_reg  <= op_next;
        acc_reg <= acc_next;
        q_reg   <= q_next;
        m_reg   <= m_next;
        nq_reg  <= nq_next;
        nr_reg  <= nr_next;
    end

    assign stat.busy  = busy_reg;
    assign stat.done  = done_reg;
    assign stat.write = wr_reg;
    assign stat.hi    = acc_reg;
    assign stat.lo    = q_reg;

`ifndef NO_ASSERTIONS
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.done |=> !stat.done) else $error("done held");
    a_write_done: assert property (@(posedge aclk) disable iff (!aresetn)
        stat.write |-> stat.done) else $error("write without done");
    a_no_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> !cmd.start) else $error("start while busy");
`endif
endmodule

/* rtl/mips_integer_core_step.sv */
// MIPS I integer core, one instruction or load-data request per item.
// Each request passes through register file read, execute and output; mult/div
// add a bit-serial pass, which a divide by zero skips.
// One request at a time: the next is accepted only after the result is taken.
// Reset (aresetn low, synchronous) clears registers, hi/lo, pc and pending
// state; the register file reads zero until written via per-entry valid bits.
module mips_integer_core_step (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [31:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic        s_tuser,   // req_type
    input  logic [63:0] s_tdata,   // instruction_word[31:0], load_data[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [103:0] m_tdata,  // fetch_address, mem_request, mem_width,
                                   // mem_address, store_data, syscall_request
    output logic        m_tuser    // unused flag, held low
);
    mics_pkg::state_t state_reg, state_next;

    logic        req_reg;
    logic [31:0] iw_reg;
    logic [31:0] ld_reg;
    logic [31:0] pc_reg, pc_next;
    logic [31:0] bt_reg, bt_next;
    logic        dp_reg, dp_next;
    logic [4:0]  ldst_reg, ldst_next;
    mics_pkg::load_kind_t lk_reg, lk_next;
    logic [31:0] hi_reg, hi_next;
    logic [31:0] lo_reg, lo_next;

    // result holding register
    logic [31:0] o_fa_reg, o_fa_next;
    logic [1:0]  o_mr_reg, o_mr_next;
    logic [1:0]  o_mw_reg, o_mw_next;
    logic [31:0] o_ma_reg, o_ma_next;
    logic [31:0] o_sd_reg, o_sd_next;
    logic        o_sc_reg, o_sc_next;

    logic        accept;
    logic [31:0] a, b;
    logic        rf_we;
    logic [4:0]  rf_wa;
    logic [31:0] rf_wd;
    mics_pkg::md_cmd_t  md_cmd;
    mics_pkg::md_stat_t md_stat;

    logic [5:0]  op, fn;
    logic [4:0]  rs, rt, rd, sa;
    logic [31:0] imm, simm, slot, btgt, ea, jtgt, link;
    logic        taken;
    logic [31:0] tgt;

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == mics_pkg::ST_IDLE);
    assign m_tvalid = (state_reg == mics_pkg::ST_OUT);
    assign m_tuser  = 1'b0;
    assign m_tdata  = {3'd0, o_sc_reg, o_sd_reg, o_ma_reg, o_mw_reg, o_mr_reg, o_fa_reg};

    // decode fields
    assign op   = iw_reg[31:26];
    assign rs   = iw_reg[25:21];
    assign rt   = iw_reg[20:16];
    assign rd   = iw_reg[15:11];
    assign sa   = iw_reg[10:6];
    assign fn   = iw_reg[5:0];
    assign imm  = {16'd0, iw_reg[15:0]};
    assign simm = {{16{iw_reg[15]}}, iw_reg[15:0]};
    assign slot = pc_reg + 32'd4;
    assign link = pc_reg + 32'd8;
    assign btgt = slot + {simm[29:0], 2'b00};
    assign ea   = a + simm;
    assign jtgt = {slot[31:28], iw_reg[25:0], 2'b00};

    // read operands from the captured word; data is ready in ST_EXEC
    mics_regfile u_rf (
        .aclk(aclk), .aresetn(aresetn),
        .we(rf_we), .waddr(rf_wa), .wdata(rf_wd),
        .raddr_a(rs), .raddr_b(rt),
        .rdata_a(a), .rdata_b(b)
    );

    mics_muldiv u_md (
        .aclk(aclk), .aresetn(aresetn), .cmd(md_cmd),
        .op_a(a), .op_b(b), .stat(md_stat)
    );

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mics_pkg::ST_IDLE: if (accept) state_next = mics_pkg::ST_READ;
            mics_pkg::ST_READ: state_next = mics_pkg::ST_EXEC;
            mics_pkg::ST_EXEC: state_next = md_cmd.start ? mics_pkg::ST_MDU
                                                         : mics_pkg::ST_OUT;
            mics_pkg::ST_MDU:  if (md_stat.done) state_next = mics_pkg::ST_OUT;
            mics_pkg::ST_OUT:  if (m_tready) state_next = mics_pkg::ST_IDLE;
            default:           state_next = mics_pkg::ST_IDLE;
        endcase
    end

    // execute
    always_comb begin
        pc_next   = pc_reg;
        bt_next   = bt_reg;
        dp_next   = dp_reg;
        ldst_next = ldst_reg;
        lk_next   = lk_reg;
        hi_next   = hi_reg;
        lo_next   = lo_reg;
        o_fa_next = o_fa_reg;
        o_mr_next = o_mr_reg;
        o_mw_next = o_mw_reg;
        o_ma_next = o_ma_reg;
        o_sd_next = o_sd_reg;
        o_sc_next = o_sc_reg;
        rf_we     = 1'b0;
        rf_wa     = rd;
        rf_wd     = '0;
        md_cmd.start = 1'b0;
        md_cmd.op    = mics_pkg::MD_MULT;
        taken     = 1'b0;
        tgt       = '0;

        if (cfg_we) begin
            pc_next = cfg_wdata;
        end

        if (md_stat.write) begin
            hi_next = md_stat.hi;
            lo_next = md_stat.lo;
        end

        if (state_reg == mics_pkg::ST_EXEC) begin
            o_mr_next = mics_pkg::MREQ_NONE;
            o_mw_next = mics_pkg::MW_BYTE;
            o_ma_next = '0;
            o_sd_next = '0;
            o_sc_next = 1'b0;
            if (req_reg) begin
                // load data: extend and write back
                rf_wa = ldst_reg;
                case (lk_reg)
                    mics_pkg::LK_LB: begin
                        rf_we = 1'b1; rf_wd = {{24{ld_reg[7]}}, ld_reg[7:0]};
                    end
                    mics_pkg::LK_LH: begin
                        rf_we = 1'b1; rf_wd = {{16{ld_reg[15]}}, ld_reg[15:0]};
                    end
                    mics_pkg::LK_LW: begin
                        rf_we = 1'b1; rf_wd = ld_reg;
                    end
                    mics_pkg::LK_LBU: begin
                        rf_we = 1'b1; rf_wd = {24'd0, ld_reg[7:0]};
                    end
                    mics_pkg::LK_LHU: begin
                        rf_we = 1'b1; rf_wd = {16'd0, ld_reg[15:0]};
                    end
                    default: rf_we = 1'b0;
                endcase
                lk_next = mics_pkg::LK_NONE;
            end else begin
                lk_next = mics_pkg::LK_NONE;
                unique case (op)
                    mics_pkg::OP_SPECIAL: begin
                        rf_wa = rd;
                        case (fn)
                            mics_pkg::FN_SLL:  begin rf_we = 1'b1; rf_wd = b << sa; end
                            mics_pkg::FN_SRL:  begin rf_we = 1'b1; rf_wd = b >> sa; end
                            mics_pkg::FN_SRA:  begin
                                rf_we = 1'b1; rf_wd = $unsigned($signed(b) >>> sa);
                            end
                            mics_pkg::FN_SLLV: begin rf_we = 1'b1; rf_wd = b << a[4:0]; end
                            mics_pkg::FN_SRLV: begin rf_we = 1'b1; rf_wd = b >> a[4:0]; end
                            mics_pkg::FN_SRAV: begin
                                rf_we = 1'b1; rf_wd = $unsigned($signed(b) >>> a[4:0]);
                            end
                            mics_pkg::FN_JR:   begin taken = 1'b1; tgt = a; end
                            mics_pkg::FN_JALR: begin
                                taken = 1'b1; tgt = a; rf_we = 1'b1; rf_wd = link;
                            end
                            mics_pkg::FN_SYSCALL: o_sc_next = 1'b1;
                            mics_pkg::FN_MFHI: begin rf_we = 1'b1; rf_wd = hi_reg; end
                            mics_pkg::FN_MTHI: hi_next = a;
                            mics_pkg::FN_MFLO: begin rf_we = 1'b1; rf_wd = lo_reg; end
                            mics_pkg::FN_MTLO: lo_next = a;
                            mics_pkg::FN_MULT: begin
                                md_cmd.start = 1'b1; md_cmd.op = mics_pkg::MD_MULT;
                            end
                            mics_pkg::FN_MULTU: begin
                                md_cmd.start = 1'b1; md_cmd.op = mics_pkg::MD_MULTU;
                            end
                            mics_pkg::FN_DIV: begin
                                md_cmd.start = 1'b1; md_cmd.op = mics_pkg::MD_DIV;
                            end
                            mics_pkg::FN_DIVU: begin
                                md_cmd.start = 1'b1; md_cmd.op = mics_pkg::MD_DIVU;
                            end
                            mics_pkg::FN_ADD, mics_pkg::FN_ADDU: begin
                                rf_we = 1'b1; rf_wd = a + b;
                            end
                            mics_pkg::FN_SUB, mics_pkg::FN_SUBU: begin
                                rf_we = 1'b1; rf_wd = a - b;
                            end
                            mics_pkg::FN_AND: begin rf_we = 1'b1; rf_wd = a & b; end
                            mics_pkg::FN_OR:  begin rf_we = 1'b1; rf_wd = a | b; end
                            mics_pkg::FN_XOR: begin rf_we = 1'b1; rf_wd = a ^ b; end
                            mics_pkg::FN_NOR: begin rf_we = 1'b1; rf_wd = ~(a | b); end
                            mics_pkg::FN_SLT: begin
                                rf_we = 1'b1;
                                rf_wd = {31'd0, ($signed(a) < $signed(b))};
                            end
                            mics_pkg::FN_SLTU: begin
                                rf_we = 1'b1; rf_wd = {31'd0, (a < b)};
                            end
                            default: rf_we = 1'b0;
                        endcase
                    end
                    mics_pkg::OP_REGIMM: begin
                        rf_wa = mics_pkg::REG_RA;
                        rf_wd = link;
                        rf_we = (rt == mics_pkg::RT_BLTZAL);
                        if (a[31]) begin taken = 1'b1; tgt = btgt; end
                    end
                    mics_pkg::OP_J: begin taken = 1'b1; tgt = jtgt; end
                    mics_pkg::OP_JAL: begin
                        rf_wa = mics_pkg::REG_RA; rf_wd = link; rf_we = 1'b1;
                        taken = 1'b1; tgt = jtgt;
                    end
                    mics_pkg::OP_BEQ:  if (a == b) begin taken = 1'b1; tgt = btgt; end
                    mics_pkg::OP_BNE:  if (a != b) begin taken = 1'b1; tgt = btgt; end
                    mics_pkg::OP_BLEZ: if (a[31] || a == 32'd0) begin
                        taken = 1'b1; tgt = btgt;
                    end
                    mics_pkg::OP_BGTZ: if (!a[31] && a != 32'd0) begin
                        taken = 1'b1; tgt = btgt;
                    end
                    mics_pkg::OP_ADDI, mics_pkg::OP_ADDIU: begin
                        rf_wa = rt; rf_we = 1'b1; rf_wd = ea;
                    end
                    mics_pkg::OP_SLTI: begin
                        rf_wa = rt; rf_we = 1'b1;
                        rf_wd = {31'd0, ($signed(a) < $signed(simm))};
                    end
                    mics_pkg::OP_SLTIU: begin
                        rf_wa = rt; rf_we = 1'b1; rf_wd = {31'd0, (a < simm)};
                    end
                    mics_pkg::OP_ANDI: begin rf_wa = rt; rf_we = 1'b1; rf_wd = a & imm; end
                    mics_pkg::OP_ORI:  begin rf_wa = rt; rf_we = 1'b1; rf_wd = a | imm; end
                    mics_pkg::OP_XORI: begin rf_wa = rt; rf_we = 1'b1; rf_wd = a ^ imm; end
                    mics_pkg::OP_LUI: begin
                        rf_wa = rt; rf_we = 1'b1; rf_wd = {iw_reg[15:0], 16'd0};
                    end
                    mics_pkg::OP_LB, mics_pkg::OP_LH, mics_pkg::OP_LW,
                    mics_pkg::OP_LBU, mics_pkg::OP_LHU: begin
                        o_mr_next = mics_pkg::MREQ_LOAD;
                        o_ma_next = ea;
                        ldst_next = rt;
                        case (op)
                            mics_pkg::OP_LB: begin
                                o_mw_next = mics_pkg::MW_BYTE; lk_next = mics_pkg::LK_LB;
                            end
                            mics_pkg::OP_LH: begin
                                o_mw_next = mics_pkg::MW_HALF; lk_next = mics_pkg::LK_LH;
                            end
                            mics_pkg::OP_LW: begin
                                o_mw_next = mics_pkg::MW_WORD; lk_next = mics_pkg::LK_LW;
                            end
                            mics_pkg::OP_LBU: begin
                                o_mw_next = mics_pkg::MW_BYTE; lk_next = mics_pkg::LK_LBU;
                            end
                            default: begin
                                o_mw_next = mics_pkg::MW_HALF; lk_next = mics_pkg::LK_LHU;
                            end
                        endcase
                    end
                    mics_pkg::OP_SB: begin
                        o_mr_next = mics_pkg::MREQ_STORE; o_mw_next = mics_pkg::MW_BYTE;
                        o_ma_next = ea; o_sd_next = {24'd0, b[7:0]};
                    end
                    mics_pkg::OP_SH: begin
                        o_mr_next = mics_pkg::MREQ_STORE; o_mw_next = mics_pkg::MW_HALF;
                        o_ma_next = ea; o_sd_next = {16'd0, b[15:0]};
                    end
                    mics_pkg::OP_SW: begin
                        o_mr_next = mics_pkg::MREQ_STORE; o_mw_next = mics_pkg::MW_WORD;
                        o_ma_next = ea; o_sd_next = b;
                    end
                    default: rf_we = 1'b0;
                endcase
                // advance pc; a pending branch wins over sequential flow
                pc_next = dp_reg ? bt_reg : slot;
                dp_next = taken;
                bt_next = taken ? tgt : 32'd0;
            end
            o_fa_next = pc_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= mics_pkg::ST_IDLE;
            pc_reg    <= '0;
            bt_reg    <= '0;
            dp_reg    <= 1'b0;
            ldst_reg  <= '0;
            lk_reg    <= mics_pkg::LK_NONE;
            hi_reg    <= '0;
            lo_reg    <= '0;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            bt_reg    <= bt_next;
            dp_reg    <= dp_next;
            ldst_reg  <= ldst_next;
            lk_reg    <= lk_next;
            hi_reg    <= hi_next;
            lo_reg    <= lo_next;
        end
    end

    // capture request and result payload
    always_ff @(posedge aclk) begin
        if (accept) begin
            req_reg <= s_tuser;
            iw_reg  <= s_tdata[31:0];
            ld_reg  <= s_tdata[63:32];
        end
        o_fa_reg <= o_fa_next;
        o_mr_reg <= o_mr_next;
        o_mw_reg <= o_mw_next;
        o_ma_reg <= o_ma_next;
        o_sd_reg <= o_sd_next;
        o_sc_reg <= o_sc_next;
    end

`ifndef NO_ASSERTIONS
    a_one_side: assert property (@(posedge aclk) disable iff (!aresetn)
        !(s_tready && m_tvalid)) else $error("accept while result pending");
    a_md_only_mdu: assert property (@(posedge aclk) disable iff (!aresetn)
        md_stat.busy |-> state_reg == mics_pkg::ST_MDU) else $error("mdu busy outside");
    a_load_req: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && o_mr_reg == mics_pkg::MREQ_LOAD) |-> lk_reg != mics_pkg::LK_NONE)
        else $error("load without kind");
`endif
endmodule

/* verif/tb_mips_integer_core_step.sv */
// Testbench for mips_integer_core_step: drives instruction and load-data requests,
// predicts each result with its own model of the core, and checks every result.
// Depends on rtl/mics_pkg.sv and rtl/mips_integer_core_step.sv.
module tb_mips_integer_core_step;

    localparam int SETTLE_CYCLES = 48;     // longer than a mult/div pass
    localparam int CYCLE_LIMIT   = 1000000;

    typedef struct {
        logic [31:0] fetch_address;
        logic [1:0]  mem_request;
        logic [1:0]  mem_width;
        logic [31:0] mem_address;
        logic [31:0] store_data;
        logic        syscall_request;
    } core_result_t;

    logic         aclk = 1'b0;
    logic         aresetn = 1'b0;
    logic         cfg_we = 1'b0;
    logic [31:0]  cfg_wdata = '0;
    logic         s_tvalid = 1'b0;
    logic         s_tready;
    logic         s_tuser = 1'b0;
    logic [63:0]  s_tdata = '0;
    logic         m_tvalid;
    logic         m_tready = 1'b0;
    logic [103:0] m_tdata;
    logic         m_tuser;

    mips_integer_core_step DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tuser   (s_tuser),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // predicted architectural state of the core
    logic [31:0] start_addr;
    logic [31:0] gpr [32];
    logic [31:0] hi_q, lo_q, pc_q, branch_tgt_q;
    logic        in_delay_slot;
    logic [4:0]  load_dest_q;
    mics_pkg::load_kind_t load_kind_q;

    core_result_t expected_results[$];
    int  error_count = 0;
    int  cycle_count = 0;
    int  sender_idle_pct = 0;
    int  receiver_stall_pct = 0;
    int  hold_off_cycles = 0;

    // ---------------------------------------------------------------- predictor

    task automatic put_gpr(input logic [4:0] idx, input logic [31:0] val);
        if (idx != 5'd0) gpr[idx] = val;
    endtask

    task automatic predict_core(input logic is_data, input logic [31:0] w,
                                input logic [31:0] ld, output core_result_t r);
        logic [5:0]  op, fn;
        logic [4:0]  rs, rt, rd, sa;
        logic [31:0] a, b, simm, imm, slot, btgt, ea, jtgt, tgt, next, ua, ub, q, rem;
        logic [63:0] prod;
        logic        taken;
        r = '{default: '0};
        if (is_data) begin
            // only a pending load consumes the data; otherwise drop it
            case (load_kind_q)
                mics_pkg::LK_LB:  put_gpr(load_dest_q, {{24{ld[7]}}, ld[7:0]});
                mics_pkg::LK_LH:  put_gpr(load_dest_q, {{16{ld[15]}}, ld[15:0]});
                mics_pkg::LK_LW:  put_gpr(load_dest_q, ld);
                mics_pkg::LK_LBU: put_gpr(load_dest_q, {24'd0, ld[7:0]});
                mics_pkg::LK_LHU: put_gpr(load_dest_q, {16'd0, ld[15:0]});
                default: ;
            endcase
            load_kind_q = mics_pkg::LK_NONE;
        end else begin
            op = w[31:26]; rs = w[25:21]; rt = w[20:16]; rd = w[15:11];
            sa = w[10:6];  fn = w[5:0];
            imm  = {16'd0, w[15:0]};
            simm = {{16{w[15]}}, w[15:0]};
            a = gpr[rs]; b = gpr[rt];
            slot = pc_q + 32'd4;
            btgt = slot + (simm << 2);
            ea   = a + simm;
            jtgt = {slot[31:28], w[25:0], 2'b00};
            next = in_delay_slot ? branch_tgt_q : slot;
            taken = 1'b0; tgt = '0;
            load_kind_q = mics_pkg::LK_NONE;   // an instruction cancels a pending load
            case (op)
                mics_pkg::OP_SPECIAL: case (fn)
                    mics_pkg::FN_SLL:  put_gpr(rd, b << sa);
                    mics_pkg::FN_SRL:  put_gpr(rd, b >> sa);
                    mics_pkg::FN_SRA:  put_gpr(rd, $signed(b) >>> sa);
                    mics_pkg::FN_SLLV: put_gpr(rd, b << a[4:0]);
                    mics_pkg::FN_SRLV: put_gpr(rd, b >> a[4:0]);
                    mics_pkg::FN_SRAV: put_gpr(rd, $signed(b) >>> a[4:0]);
                    mics_pkg::FN_JR:   begin taken = 1'b1; tgt = a; end
                    mics_pkg::FN_JALR: begin
                        taken = 1'b1; tgt = a; put_gpr(rd, pc_q + 32'd8);
                    end
                    mics_pkg::FN_SYSCALL: r.syscall_request = 1'b1;
                    mics_pkg::FN_MFHI: put_gpr(rd, hi_q);
                    mics_pkg::FN_MTHI: hi_q = a;
                    mics_pkg::FN_MFLO: put_gpr(rd, lo_q);
                    mics_pkg::FN_MTLO: lo_q = a;
                    mics_pkg::FN_MULT: begin
                        prod = $signed({{32{a[31]}}, a}) * $signed({{32{b[31]}}, b});
                        hi_q = prod[63:32]; lo_q = prod[31:0];
                    end
                    mics_pkg::FN_MULTU: begin
                        prod = {32'd0, a} * {32'd0, b};
                        hi_q = prod[63:32]; lo_q = prod[31:0];
                    end
                    mics_pkg::FN_DIV: if (b != 0) begin
                        ua = a[31] ? -a : a;
                        ub = b[31] ? -b : b;
                        q = ua / ub; rem = ua % ub;
                        lo_q = (a[31] ^ b[31]) ? -q : q;
                        hi_q = a[31] ? -rem : rem;
                    end
                    mics_pkg::FN_DIVU: if (b != 0) begin
                        lo_q = a / b; hi_q = a % b;
                    end
                    mics_pkg::FN_ADD, mics_pkg::FN_ADDU: put_gpr(rd, a + b);
                    mics_pkg::FN_SUB, mics_pkg::FN_SUBU: put_gpr(rd, a - b);
                    mics_pkg::FN_AND:  put_gpr(rd, a & b);
                    mics_pkg::FN_OR:   put_gpr(rd, a | b);
                    mics_pkg::FN_XOR:  put_gpr(rd, a ^ b);
                    mics_pkg::FN_NOR:  put_gpr(rd, ~(a | b));
                    mics_pkg::FN_SLT:  put_gpr(rd, {31'd0, $signed(a) < $signed(b)});
                    mics_pkg::FN_SLTU: put_gpr(rd, {31'd0, a < b});
                    default: ;
                endcase
                mics_pkg::OP_REGIMM: begin
                    if (rt == mics_pkg::RT_BLTZAL) put_gpr(mics_pkg::REG_RA, pc_q + 32'd8);
                    if (a[31]) begin taken = 1'b1; tgt = btgt; end
                end
                mics_pkg::OP_J:    begin taken = 1'b1; tgt = jtgt; end
                mics_pkg::OP_JAL:  begin
                    put_gpr(mics_pkg::REG_RA, pc_q + 32'd8); taken = 1'b1; tgt = jtgt;
                end
                mics_pkg::OP_BEQ:  if (a == b) begin taken = 1'b1; tgt = btgt; end
                mics_pkg::OP_BNE:  if (a != b) begin taken = 1'b1; tgt = btgt; end
                mics_pkg::OP_BLEZ: if (a[31] || a == 0) begin taken = 1'b1; tgt = btgt; end
                mics_pkg::OP_BGTZ: if (!a[31] && a != 0) begin taken = 1'b1; tgt = btgt; end
                mics_pkg::OP_ADDI, mics_pkg::OP_ADDIU: put_gpr(rt, ea);
                mics_pkg::OP_SLTI:  put_gpr(rt, {31'd0, $signed(a) < $signed(simm)});
                mics_pkg::OP_SLTIU: put_gpr(rt, {31'd0, a < simm});
                mics_pkg::OP_ANDI:  put_gpr(rt, a & imm);
                mics_pkg::OP_ORI:   put_gpr(rt, a | imm);
                mics_pkg::OP_XORI:  put_gpr(rt, a ^ imm);
                mics_pkg::OP_LUI:   put_gpr(rt, {w[15:0], 16'd0});
                mics_pkg::OP_LB, mics_pkg::OP_LH, mics_pkg::OP_LW,
                mics_pkg::OP_LBU, mics_pkg::OP_LHU: begin
                    r.mem_request = mics_pkg::MREQ_LOAD;
                    r.mem_address = ea;
                    load_dest_q = rt;
                    case (op)
                        mics_pkg::OP_LB: begin
                            r.mem_width = mics_pkg::MW_BYTE; load_kind_q = mics_pkg::LK_LB;
                        end
                        mics_pkg::OP_LH: begin
                            r.mem_width = mics_pkg::MW_HALF; load_kind_q = mics_pkg::LK_LH;
                        end
                        mics_pkg::OP_LW: begin
                            r.mem_width = mics_pkg::MW_WORD; load_kind_q = mics_pkg::LK_LW;
                        end
                        mics_pkg::OP_LBU: begin
                            r.mem_width = mics_pkg::MW_BYTE; load_kind_q = mics_pkg::LK_LBU;
                        end
                        default: begin
                            r.mem_width = mics_pkg::MW_HALF; load_kind_q = mics_pkg::LK_LHU;
                        end
                    endcase
                end
                mics_pkg::OP_SB: begin
                    r.mem_request = mics_pkg::MREQ_STORE; r.mem_width = mics_pkg::MW_BYTE;
                    r.mem_address = ea; r.store_data = {24'd0, b[7:0]};
                end
                mics_pkg::OP_SH: begin
                    r.mem_request = mics_pkg::MREQ_STORE; r.mem_width = mics_pkg::MW_HALF;
                    r.mem_address = ea; r.store_data = {16'd0, b[15:0]};
                end
                mics_pkg::OP_SW: begin
                    r.mem_request = mics_pkg::MREQ_STORE; r.mem_width = mics_pkg::MW_WORD;
                    r.mem_address = ea; r.store_data = b;
                end
                default: ;
            endcase
            pc_q = next;
            in_delay_slot = taken;
            branch_tgt_q = taken ? tgt : 32'd0;
        end
        r.fetch_address = pc_q;
    endtask

    // ------------------------------------------------------------ drivers

    function automatic logic [31:0] enc_r(logic [5:0] fn, logic [4:0] rs, logic [4:0] rt,
                                          logic [4:0] rd, logic [4:0] sa = 5'd0);
        return {mics_pkg::OP_SPECIAL, rs, rt, rd, sa, fn};
    endfunction

    function automatic logic [31:0] enc_i(logic [5:0] op, logic [4:0] rs, logic [4:0] rt,
                                          logic [15:0] imm);
        return {op, rs, rt, imm};
    endfunction

    // Offer one request; hold it until accepted, then record its prediction.
    task automatic send_request(input logic is_data, input logic [31:0] w,
                                input logic [31:0] ld);
        int gap;
        core_result_t r;
        gap = 0;
        while (sender_idle_pct > 0 && $urandom_range(99) < sender_idle_pct && gap < 20)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= is_data;
        s_tdata  <= {ld, w};
        do @(posedge aclk); while (!s_tready);
        predict_core(is_data, w, ld, r);
        expected_results.push_back(r);
    endtask

    task automatic exec_instr(input logic [31:0] w);
        send_request(1'b0, w, $urandom);
    endtask

    task automatic return_load(input logic [31:0] ld);
        send_request(1'b1, $urandom, ld);
    endtask

    // Drop valid and let the core drain every outstanding result.
    task automatic wait_idle();
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic write_start_address(input logic [31:0] v);
        cfg_we    <= 1'b1;
        cfg_wdata <= v;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        start_addr = v;
        pc_q = v;
    endtask

    // ----------------------------------------------------- result checking

    always @(posedge aclk) begin
        core_result_t exp_r;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_results.size() == 0) begin
                $error("result with no request outstanding: %h", m_tdata);
                error_count++;
            end else begin
                exp_r = expected_results.pop_front();
                if (m_tdata[31:0] !== exp_r.fetch_address) begin
                    $error("fetch_address expected %h got %h", exp_r.fetch_address,
                           m_tdata[31:0]);
                    error_count++;
                end
                if (m_tdata[33:32] !== exp_r.mem_request) begin
                    $error("mem_request expected %0d got %0d", exp_r.mem_request,
                           m_tdata[33:32]);
                    error_count++;
                end
                if (m_tdata[35:34] !== exp_r.mem_width) begin
                    $error("mem_width expected %0d got %0d", exp_r.mem_width,
                           m_tdata[35:34]);
                    error_count++;
                end
                if (m_tdata[67:36] !== exp_r.mem_address) begin
                    $error("mem_address expected %h got %h", exp_r.mem_address,
                           m_tdata[67:36]);
                    error_count++;
                end
                if (m_tdata[99:68] !== exp_r.store_data) begin
                    $error("store_data expected %h got %h", exp_r.store_data,
                           m_tdata[99:68]);
                    error_count++;
                end
                if (m_tdata[100] !== exp_r.syscall_request) begin
                    $error("syscall_request expected %b got %b", exp_r.syscall_request,
                           m_tdata[100]);
                    error_count++;
                end
            end
        end
    end

    // Receiver: random stalls, plus a long hold-off when a test asks for one.
    always @(posedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_tready <= 1'b0;
            hold_off_cycles <= hold_off_cycles - 1;
        end else begin
            m_tready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    // Watchdog: fail the run if it hangs.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    // ------------------------------------------------------------- tests

    // Extremes, every special case, one of each kind of request.
    task automatic test_directed();
        exec_instr(enc_i(mics_pkg::OP_LUI, 5'd0, 5'd1, 16'h8000));   // r1 = 0x80000000
        exec_instr(enc_i(mics_pkg::OP_ADDIU, 5'd0, 5'd2, 16'hFFFF)); // r2 = -1
        exec_instr(enc_i(mics_pkg::OP_ADDI, 5'd0, 5'd0, 16'h1234));  // write to r0 dropped
        exec_instr(enc_r(mics_pkg::FN_ADD, 5'd1, 5'd1, 5'd3));       // add wraps, no trap
        exec_instr(enc_r(mics_pkg::FN_SRA, 5'd0, 5'd1, 5'd4, 5'd31)); // arithmetic shift
        exec_instr(enc_r(mics_pkg::FN_SRAV, 5'd2, 5'd1, 5'd5));      // shift by low 5 bits
        exec_instr(enc_r(mics_pkg::FN_SLT, 5'd1, 5'd2, 5'd6));       // signed compare
        exec_instr(enc_r(mics_pkg::FN_MULT, 5'd1, 5'd2, 5'd0));
        exec_instr(enc_r(mics_pkg::FN_DIV, 5'd1, 5'd2, 5'd0));       // most negative / -1
        exec_instr(enc_r(mics_pkg::FN_DIVU, 5'd1, 5'd0, 5'd0));      // divide by zero
        exec_instr(enc_r(mics_pkg::FN_MFHI, 5'd0, 5'd0, 5'd7));
        exec_instr(enc_r(mics_pkg::FN_MFLO, 5'd0, 5'd0, 5'd8));
        exec_instr(enc_i(mics_pkg::OP_REGIMM, 5'd1, mics_pkg::RT_BLTZAL, 16'h0004));
        exec_instr(enc_i(mics_pkg::OP_BEQ, 5'd0, 5'd0, 16'hFFF0));   // branch in delay slot
        exec_instr(enc_r(mics_pkg::FN_SYSCALL, 5'd0, 5'd0, 5'd0));
        exec_instr({mics_pkg::OP_J, 26'h3FFFFFF});                   // jump keeps top bits
        exec_instr(enc_i(mics_pkg::OP_SB, 5'd1, 5'd2, 16'h8000));    // store masked to byte
        exec_instr(enc_i(mics_pkg::OP_LB, 5'd2, 5'd9, 16'h7FFF));
        return_load(32'hFFFFFF80);                         // sign-extend, high bits ignored
        return_load(32'h12345678);                         // no load pending: ignored
        exec_instr(enc_i(mics_pkg::OP_LW, 5'd0, 5'd10, 16'h0000));
        exec_instr(enc_r(mics_pkg::FN_SUBU, 5'd9, 5'd2, 5'd11));     // cancels pending load
        return_load(32'hDEADBEEF);
        exec_instr({6'h1A, 26'h1555555});                            // unknown opcode
        exec_instr(enc_r(6'h3F, 5'd1, 5'd2, 5'd12));                 // unknown function
    endtask

    function automatic logic [4:0] pick_reg();
        return ($urandom_range(9) < 8) ? 5'($urandom_range(7)) : 5'($urandom);
    endfunction

    function automatic logic [31:0] rand_instr();
        logic [5:0] ops[] = '{mics_pkg::OP_SPECIAL, mics_pkg::OP_SPECIAL,
                              mics_pkg::OP_SPECIAL, mics_pkg::OP_REGIMM, mics_pkg::OP_J,
                              mics_pkg::OP_JAL, mics_pkg::OP_BEQ, mics_pkg::OP_BNE,
                              mics_pkg::OP_BLEZ, mics_pkg::OP_BGTZ, mics_pkg::OP_ADDI,
                              mics_pkg::OP_ADDIU, mics_pkg::OP_SLTI, mics_pkg::OP_SLTIU,
                              mics_pkg::OP_ANDI, mics_pkg::OP_ORI, mics_pkg::OP_XORI,
                              mics_pkg::OP_LUI, mics_pkg::OP_LB, mics_pkg::OP_LH,
                              mics_pkg::OP_LW, mics_pkg::OP_LBU, mics_pkg::OP_LHU,
                              mics_pkg::OP_SB, mics_pkg::OP_SH, mics_pkg::OP_SW};
        logic [5:0] fns[] = '{mics_pkg::FN_SLL, mics_pkg::FN_SRL, mics_pkg::FN_SRA,
                              mics_pkg::FN_SLLV, mics_pkg::FN_SRLV, mics_pkg::FN_SRAV,
                              mics_pkg::FN_JR, mics_pkg::FN_JALR, mics_pkg::FN_SYSCALL,
                              mics_pkg::FN_MFHI, mics_pkg::FN_MTHI, mics_pkg::FN_MFLO,
                              mics_pkg::FN_MTLO, mics_pkg::FN_MULT, mics_pkg::FN_MULTU,
                              mics_pkg::FN_DIV, mics_pkg::FN_DIVU, mics_pkg::FN_ADD,
                              mics_pkg::FN_ADDU, mics_pkg::FN_SUB, mics_pkg::FN_SUBU,
                              mics_pkg::FN_AND, mics_pkg::FN_OR, mics_pkg::FN_XOR,
                              mics_pkg::FN_NOR, mics_pkg::FN_SLT, mics_pkg::FN_SLTU};
        logic [5:0] op;
        logic [4:0] rt;
        if ($urandom_range(19) == 0) return $urandom;           // raw noise word
        op = ops[$urandom_range(ops.size() - 1)];
        rt = (op == mics_pkg::OP_REGIMM && $urandom_range(1)) ? mics_pkg::RT_BLTZAL
                                                               : pick_reg();
        if (op == mics_pkg::OP_SPECIAL)
            return enc_r(fns[$urandom_range(fns.size() - 1)], pick_reg(), rt, pick_reg(),
                         5'($urandom));
        return {op, pick_reg(), rt, 16'($urandom)};
    endfunction

    // Mostly well-formed: a load is usually followed by its data.
    task automatic test_random(input int n_items, input int idle_pct, input int stall_pct);
        logic [31:0] w;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n_items) begin
            w = rand_instr();
            exec_instr(w);
            if (w[31:26] inside {mics_pkg::OP_LB, mics_pkg::OP_LH, mics_pkg::OP_LW,
                                 mics_pkg::OP_LBU, mics_pkg::OP_LHU} &&
                $urandom_range(9) < 8)
                return_load($urandom);
            else if ($urandom_range(29) == 0)
                return_load($urandom);
        end
        wait_idle();
    endtask

    task automatic test_start_addresses();
        logic [31:0] addrs[] = '{32'hFFFF_FFFF, 32'hFFFF_FFFC, 32'h8000_0000, 32'h0};
        foreach (addrs[i]) begin
            write_start_address(addrs[i]);
            test_random(10, 0, 0);
        end
        write_start_address($urandom);
    endtask

    // Hold the receiver off so the core fills and stalls its input.
    task automatic test_backpressure();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 300;
        repeat (20) exec_instr(rand_instr());
        wait_idle();
    endtask

    // Pause the sender until every outstanding result has returned.
    task automatic test_sender_pause();
        sender_idle_pct = 0;
        receiver_stall_pct = 31;
        repeat (5) exec_instr(rand_instr());
        s_tvalid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (5) exec_instr(rand_instr());
        wait_idle();
    endtask

    initial begin
        start_addr = '0;
        foreach (gpr[i]) gpr[i] = '0;
        hi_q = '0; lo_q = '0; pc_q = '0; branch_tgt_q = '0;
        in_delay_slot = 1'b0; load_dest_q = '0; load_kind_q = mics_pkg::LK_NONE;
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);
        write_start_address(32'h0040_0000);
        test_directed();
        wait_idle();
        test_start_addresses();
        test_random(70, 0, 0);
        test_random(70, 65, 0);
        test_random(70, 0, 65);
        test_random(70, 31, 31);
        test_backpressure();
        test_sender_pause();
        if (error_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

/* files.f */
rtl/mics_pkg.sv
rtl/mics_ram.sv
rtl/mics_regfile.sv
rtl/mics_muldiv.sv
rtl/mips_integer_core_step.sv
verif/tb_mips_integer_core_step.sv
